// File: src/ssfl_pkg.sv
// ssfl_pkg: shared types and constants for the sorted symbol floor lookup
// no dependencies; imported by the top level and the checker
package ssfl_pkg;

  localparam int unsigned IdWidth    = 14;
  localparam int unsigned CountWidth = 15;
  localparam int unsigned FieldAddrW = 64;

  localparam logic [1:0] KindLoad   = 2'd0;
  localparam logic [1:0] KindSearch = 2'd1;
  localparam logic [1:0] KindClear  = 2'd2;

  localparam logic ReplyLoad   = 1'b0;
  localparam logic ReplySearch = 1'b1;

  localparam logic [7:0] TypeTextLower = 8'h74;
  localparam logic [7:0] TypeTextUpper = 8'h54;

  typedef struct packed {
    logic [1:0]            kind;
    logic [FieldAddrW-1:0] sym_addr;
    logic [7:0]            sym_type;
    logic                  last_entry;
    logic [FieldAddrW-1:0] search_key;
  } in_req_t;

  typedef struct packed {
    logic                  reply_kind;
    logic                  found;
    logic [IdWidth-1:0]    entry_id;
    logic [FieldAddrW-1:0] entry_addr;
    logic [CountWidth-1:0] table_count;
    logic                  overflowed;
  } out_req_t;

endpackage

// File: src/sorted_symbol_floor_lookup_top.sv
// sorted_symbol_floor_lookup_top: table load, bottom-up merge sort, floor search
// depends on ssfl_pkg
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_req_t
//  out     | output    | out_valid/out_ready| out_req_t
//  cfg     | input     | cfg_we             | cfg_wdata (text_only)
//
// a load is taken and the block stays idle unless it carries last_entry; a search result
// comes from a binary search, one memory read per probe step; the sort after a last
// load runs ceil(log2(count)) passes ping-pong between two memory banks.
// rst_n is synchronous; memories are not cleared.
// a result waits in the output register while the next request is taken.
module sorted_symbol_floor_lookup_top
  import ssfl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16384,
  parameter int unsigned ADDR_WIDTH  = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = ADDR_WIDTH + IdWidth;
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SORT_SETUP, ST_MRG_RD, ST_MRG_WT, ST_MRG_CMP, ST_PASS_END,
    ST_SRCH_RD, ST_SRCH_WT, ST_SRCH_CMP, ST_FIN_RD, ST_FIN_WT, ST_REPLY
  } state_t;

  // two banks; each entry holds address and id
  logic [EW-1:0] bank0 [TABLE_DEPTH];
  logic [EW-1:0] bank1 [TABLE_DEPTH];
  logic [EW-1:0] rd0_r, rd1_r;
  logic [IW-1:0] raddr;
  logic          we0, we1;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdat;

  state_t          state_r;
  logic            text_only_r;
  logic [CW-1:0]   count_r;
  logic            ovf_r, sorted_r, cur_r;
  logic [CW:0]     width_r, lo_r, mid_r, hi_r, i_r, j_r, k_r;
  logic            rd_j_r;
  logic [CW:0]     slo_r, shi_r, smid_r;
  logic [ADDR_WIDTH-1:0] key_r;
  logic            out_valid_r;
  out_req_t        out_r;
  logic            fnd_r;
  logic            rkind_r;

  // memory ports: write while loading or merging, read one address
  always_ff @(posedge clk) begin
    if (we0) bank0[waddr] <= wdat;
    if (we1) bank1[waddr] <= wdat;
    rd0_r <= bank0[raddr];
    rd1_r <= bank1[raddr];
  end

  logic [EW-1:0] rd_cur;
  assign rd_cur = cur_r ? rd1_r : rd0_r;
  logic [ADDR_WIDTH-1:0] rd_addr;
  assign rd_addr = rd_cur[EW-1:IdWidth];

  // held element of the merge (the i-side element)
  logic [EW-1:0] held_r;
  logic          held_v_r;

  logic [ADDR_WIDTH-1:0] ld_addr;
  logic                  ld_keep;
  assign ld_addr = in_data.sym_addr[ADDR_WIDTH-1:0];
  assign ld_keep = (ld_addr != '0) && (!text_only_r ||
                   in_data.sym_type == TypeTextLower || in_data.sym_type == TypeTextUpper);

  logic in_fire;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  logic i_live, j_live;
  assign i_live = i_r < mid_r;
  assign j_live = j_r < hi_r;

  // read address and write port
  always_comb begin
    raddr = '0;
    we0 = 1'b0;
    we1 = 1'b0;
    waddr = '0;
    wdat = '0;
    case (state_r)
      ST_IDLE: begin
        waddr = count_r[IW-1:0];
        wdat  = {ld_addr, IdWidth'(count_r)};
        if (in_fire && in_data.kind == KindLoad && ld_keep && count_r < DepthC) begin
          we0 = !cur_r;
          we1 = cur_r;
        end
      end
      ST_MRG_RD, ST_MRG_WT: raddr = rd_j_r ? j_r[IW-1:0] : i_r[IW-1:0];
      ST_MRG_CMP: begin
        waddr = k_r[IW-1:0];
        if (held_v_r && (!j_live || !(rd_addr < held_r[EW-1:IdWidth]))) wdat = held_r;
        else wdat = rd_cur;
        if (held_v_r || rd_j_r) begin
          we0 = cur_r;
          we1 = !cur_r;
        end
      end
      ST_SRCH_RD: raddr = smid_r[IW-1:0];
      ST_FIN_RD:  raddr = IW'(slo_r - 1'b1);
      default: ;
    endcase
  end

  // control sequencer and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      text_only_r <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sorted_r    <= 1'b0;
      cur_r       <= 1'b0;
      out_valid_r <= 1'b0;
      held_v_r    <= 1'b0;
    end else begin
      if (cfg_we) text_only_r <= cfg_wdata;
      if (out_valid_r && out_ready && state_r != ST_REPLY) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_data.kind)
              KindLoad: begin
                if (ld_keep) begin
                  if (count_r < DepthC) begin
                    count_r  <= count_r + 1'b1;
                    sorted_r <= 1'b0;
                  end else ovf_r <= 1'b1;
                end
                if (in_data.last_entry) begin
                  rkind_r <= ReplyLoad;
                  state_r <= ST_SORT_SETUP;
                end
              end
              KindSearch: begin
                key_r   <= in_data.search_key[ADDR_WIDTH-1:0];
                slo_r   <= '0;
                shi_r   <= (CW+1)'(count_r);
                fnd_r   <= 1'b0;
                rkind_r <= ReplySearch;
                if (!sorted_r || count_r == '0) state_r <= ST_REPLY;
                else state_r <= ST_SRCH_CMP;
              end
              KindClear: begin
                count_r  <= '0;
                ovf_r    <= 1'b0;
                sorted_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_SORT_SETUP: begin
          lo_r    <= '0;
          if ((CW+1)'(count_r) <= (CW+1)'(1)) begin
            fnd_r   <= 1'b0;
            state_r <= ST_PASS_END;
            width_r <= (CW+1)'(count_r) + (CW+1)'(1);
          end else begin
            state_r <= ST_PASS_END;
            width_r <= '0;
          end
        end
        ST_PASS_END: begin
          // start a run pair at lo_r, set up the first pass, or finish the pass or the sort
          if (width_r != '0 && lo_r >= (CW+1)'(count_r)) begin
            cur_r   <= !cur_r;
            width_r <= width_r << 1;
            lo_r    <= '0;
            if ((width_r << 1) >= (CW+1)'(count_r)) begin
              sorted_r <= 1'b1;
              fnd_r    <= 1'b0;
              state_r  <= ST_REPLY;
            end
          end else if (width_r == '0) begin
            width_r <= (CW+1)'(1);
          end else if (width_r > (CW+1)'(count_r)) begin
            sorted_r <= 1'b1;
            state_r  <= ST_REPLY;
          end else begin
            i_r <= lo_r;
            k_r <= lo_r;
            mid_r <= (lo_r + width_r < (CW+1)'(count_r)) ? lo_r + width_r : (CW+1)'(count_r);
            hi_r  <= (lo_r + (width_r << 1) < (CW+1)'(count_r)) ?
                     lo_r + (width_r << 1) : (CW+1)'(count_r);
            j_r   <= (lo_r + width_r < (CW+1)'(count_r)) ? lo_r + width_r : (CW+1)'(count_r);
            held_v_r <= 1'b0;
            lo_r  <= lo_r + (width_r << 1);
            state_r <= ST_MRG_RD;
            rd_j_r  <= 1'b0;
          end
        end
        ST_MRG_RD: begin
          // fetch i side if none held, else j side
          if (!held_v_r && !i_live) begin
            rd_j_r <= 1'b1;
            if (!j_live) state_r <= ST_PASS_END;
            else state_r <= ST_MRG_WT;
          end else state_r <= ST_MRG_WT;
        end
        ST_MRG_WT: begin
          state_r <= ST_MRG_CMP;
        end
        ST_MRG_CMP: begin
          if (!held_v_r && !rd_j_r) begin
            // loaded the i-side element: hold it, no write this cycle
            held_r   <= rd_cur;
            held_v_r <= 1'b1;
            i_r      <= i_r + 1'b1;
            rd_j_r   <= 1'b1;
            state_r  <= j_live ? ST_MRG_RD : ST_MRG_CMP;
          end else begin
            k_r <= k_r + 1'b1;
            if (held_v_r && (!j_live || !(rd_addr < held_r[EW-1:IdWidth]))) begin
              held_v_r <= 1'b0;
              rd_j_r   <= !i_live;
            end else begin
              j_r    <= j_r + 1'b1;
              rd_j_r <= 1'b1;
            end
            if (k_r + 1'b1 >= hi_r) state_r <= ST_PASS_END;
            else state_r <= ST_MRG_RD;
          end
        end
        ST_SRCH_CMP: begin
          if (slo_r < shi_r) begin
            smid_r  <= slo_r + ((shi_r - slo_r) >> 1);
            state_r <= ST_SRCH_RD;
          end else if (slo_r == '0) state_r <= ST_REPLY;
          else state_r <= ST_FIN_RD;
        end
        ST_SRCH_RD: state_r <= ST_SRCH_WT;
        ST_SRCH_WT: begin
          if (rd_addr <= key_r) slo_r <= smid_r + 1'b1;
          else shi_r <= smid_r;
          state_r <= ST_SRCH_CMP;
        end
        ST_FIN_RD: state_r <= ST_FIN_WT;
        ST_FIN_WT: begin
          fnd_r   <= 1'b1;
          held_r  <= rd_cur;
          state_r <= ST_REPLY;
        end
        ST_REPLY: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_r.reply_kind    <= rkind_r;
            out_r.found         <= fnd_r;
            out_r.entry_id      <= fnd_r ? held_r[IdWidth-1:0] : '0;
            out_r.entry_addr    <= fnd_r ? FieldAddrW'(held_r[EW-1:IdWidth]) : '0;
            out_r.table_count   <= CountWidth'(count_r);
            out_r.overflowed    <= ovf_r;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/ssfl_checker.sv
// ssfl_props: port-level checks for the lookup top level
// depends on ssfl_pkg; bound to sorted_symbol_floor_lookup_top
module ssfl_props
  import ssfl_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input in_req_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input out_req_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no floor without a search answer
  a_found_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.reply_kind == ReplySearch)
    else $error("found on load report");

  // a found entry never has address zero
  a_found_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.entry_addr != '0)
    else $error("found entry with zero address");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind sorted_symbol_floor_lookup_top ssfl_props u_ssfl_props (.*);
